// ===== rtl/core/tcpm_pkg.sv =====
package tcpm_pkg;

    localparam int PIXEL_BITS_DEF = 16;

    // Fixed-point constants of the curve arithmetic.
    localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
    localparam logic [31:0] THREE_Q30  = 32'hC000_0000;
    localparam logic [46:0] HALF_Q30   = 47'h2000_0000;
    localparam logic [29:0] LN2_Q30    = 30'd744261118;
    localparam logic [17:0] LEVEL_MARGIN = 18'd66;

    // Pipeline schedule, counted in register stages after the input register.
    localparam int NORM_STEPS = 6;
    localparam int LOG_BITS   = 28;
    localparam int V_BITS     = 30;
    localparam int U_BITS     = 30;
    localparam int SER_TERMS  = 16;
    localparam int SER_PHASES = 3;

    localparam int ST_CLAMP   = 1;
    localparam int ST_LEVEL   = 2;
    localparam int ST_PROD    = 3;
    localparam int ST_CLASS   = 4;
    localparam int ST_DIV0    = 5;
    localparam int ST_SQR0    = ST_DIV0 + NORM_STEPS;
    localparam int ST_DIFF    = ST_SQR0 + LOG_BITS;
    localparam int ST_GEXP    = ST_DIFF + 1;
    localparam int ST_LNX     = ST_GEXP + 1;
    localparam int ST_SER0    = ST_LNX + 1;
    localparam int ST_SEREND  = ST_SER0 + SER_TERMS * SER_PHASES;
    localparam int ST_POW     = ST_SEREND + 1;
    localparam int ST_USAT    = ST_DIV0 + V_BITS;
    localparam int ST_UDIV0   = ST_USAT + 1;
    localparam int ST_SS1     = ST_UDIV0 + U_BITS;
    localparam int ST_SS2     = ST_SS1 + 1;
    localparam int ST_SS3     = ST_SS2 + 1;
    localparam int ST_MIX1    = ST_POW + 1;
    localparam int ST_MIX2    = ST_MIX1 + 1;
    localparam int ST_MIX3    = ST_MIX2 + 1;
    localparam int ST_OUT     = ST_MIX3 + 1;
    localparam int DEPTH      = ST_OUT;

    typedef enum logic [1:0] {
        CFG_BLACK = 2'd0,
        CFG_WHITE = 2'd1,
        CFG_KNEE  = 2'd2,
        CFG_GAMMA = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_ZERO  = 2'd0,
        KIND_FULL  = 2'd1,
        KIND_PLAIN = 2'd2,
        KIND_BLEND = 2'd3
    } t_kind;

    typedef struct packed {
        logic [32:0] x;
        logic [5:0]  lz;
        logic [30:0] m;
        logic [27:0] f;
    } t_log;

    typedef struct packed {
        logic [15:0] pix;
        logic        byp;
        logic [31:0] kk;
        logic [32:0] lom;
        logic [16:0] span;
        logic        zr;
        logic [31:0] num;
        logic [32:0] den;
        logic [49:0] kd;
        logic [47:0] nm;
        logic        isz;
        logic        isf;
        t_kind       kind;
        logic [49:0] xr;
        logic [33:0] d2;
        logic [15:0] q;
        logic [33:0] vr;
        logic [29:0] v;
        logic        usat;
        logic [17:0] ur;
        logic [29:0] uq;
        logic [30:0] u;
        logic [30:0] u2;
        logic [31:0] sraw;
        logic [30:0] s;
        logic [30:0] w;
        t_log        ln;
        t_log        ld;
        logic [33:0] diff;
        logic [8:0]  ip;
        logic [27:0] fr;
        logic [29:0] xs;
        logic [30:0] term;
        logic [30:0] a;
        logic [30:0] q0h;
        logic [31:0] sum;
        logic [31:0] p;
        logic [60:0] pa;
        logic [62:0] pb;
        logic [30:0] r;
        logic [46:0] rm;
        logic [15:0] code;
    } t_item;

    function automatic t_item f_clamp(t_item it, logic [16:0] black, logic [16:0] white,
                                      logic [15:0] pmax);
        logic [15:0] k;
        logic [17:0] hi;
        k = (it.pix > pmax) ? pmax : it.pix;
        hi = {1'b0, white};
        if (hi < ({1'b0, black} + LEVEL_MARGIN)) begin
            hi = {1'b0, black} + LEVEL_MARGIN;
        end
        it.pix  = k;
        it.byp  = (black == 17'd0) && white[16];
        it.kk   = {k, 16'b0};
        it.lom  = {16'b0, black} * {17'b0, pmax};
        it.span = 17'(hi - {1'b0, black});
        return it;
    endfunction

    function automatic t_item f_level(t_item it, logic [15:0] pmax);
        it.zr  = !it.byp && ({1'b0, it.kk} <= it.lom);
        it.num = it.byp ? {16'b0, it.pix} : 32'({1'b0, it.kk} - it.lom);
        it.den = it.byp ? {17'b0, pmax} : ({16'b0, it.span} * {17'b0, pmax});
        return it;
    endfunction

    function automatic t_item f_prod(t_item it, logic [16:0] knee, logic [15:0] pmax);
        it.kd  = {33'b0, knee} * {17'b0, it.den};
        it.nm  = {16'b0, it.num} * {32'b0, pmax};
        it.isz = (it.num == 32'd0);
        it.isf = ({1'b0, it.num} >= it.den);
        return it;
    endfunction

    function automatic t_item f_class(t_item it, logic [16:0] knee);
        if (it.zr || it.isz) begin
            it.kind = KIND_ZERO;
        end else if (it.isf) begin
            it.kind = KIND_FULL;
        end else if ((knee == 17'd0) || ({2'b0, it.num, 16'b0} >= it.kd)) begin
            it.kind = KIND_PLAIN;
        end else begin
            it.kind = KIND_BLEND;
        end
        it.xr    = {1'b0, it.nm, 1'b0} + {17'b0, it.den};
        it.d2    = {it.den, 1'b0};
        it.q     = '0;
        it.vr    = {2'b0, it.num};
        it.v     = '0;
        it.ln.x  = {1'b0, it.num};
        it.ln.lz = '0;
        it.ln.m  = '0;
        it.ln.f  = '0;
        it.ld.x  = it.den;
        it.ld.lz = '0;
        it.ld.m  = '0;
        it.ld.f  = '0;
        return it;
    endfunction

    // One quotient bit of the rounded code division.
    function automatic t_item f_pdiv(t_item it, int b);
        logic [49:0] t;
        t = {16'b0, it.d2} << b;
        if (it.xr >= t) begin
            it.xr = it.xr - t;
            it.q  = it.q | (16'd1 << b);
        end
        return it;
    endfunction

    // One quotient bit of the Q30 level value.
    function automatic t_item f_vdiv(t_item it, int b);
        logic [33:0] rr;
        rr = {it.vr[32:0], 1'b0};
        if (rr >= {1'b0, it.den}) begin
            rr   = rr - {1'b0, it.den};
            it.v = it.v | (30'd1 << b);
        end
        it.vr = rr;
        return it;
    endfunction

    function automatic t_log f_norm(t_log l, int sh);
        if ((l.x >> (33 - sh)) == 33'd0) begin
            l.x  = l.x << sh;
            l.lz = l.lz + 6'(sh);
        end
        return l;
    endfunction

    // One fraction bit of log2 by squaring the normalized mantissa.
    function automatic t_log f_sqr(t_log l, logic first, int b);
        logic [30:0] mc;
        logic [61:0] pr;
        logic [31:0] mm;
        mc = first ? l.x[32:2] : l.m;
        pr = {31'b0, mc} * {31'b0, mc};
        mm = pr[61:30];
        if (mm[31]) begin
            l.m = mm[31:1];
            l.f = l.f | (28'd1 << b);
        end else begin
            l.m = mm[30:0];
        end
        return l;
    endfunction

    function automatic t_item f_diff(t_item it);
        logic [33:0] lnv;
        logic [33:0] ldv;
        lnv = {6'(6'd32 - it.ln.lz), it.ln.f};
        ldv = {6'(6'd32 - it.ld.lz), it.ld.f};
        it.diff = (ldv > lnv) ? (ldv - lnv) : 34'd0;
        return it;
    endfunction

    function automatic t_item f_gexp(t_item it, logic [14:0] gamma);
        logic [48:0] g;
        g = {34'b0, gamma} * {15'b0, it.diff};
        it.ip = g[48:40];
        it.fr = g[39:12];
        return it;
    endfunction

    function automatic t_item f_lnx(t_item it);
        logic [57:0] t;
        t = {30'b0, it.fr} * {28'b0, LN2_Q30};
        it.xs   = t[57:28];
        it.term = ONE_Q30;
        it.sum  = {1'b0, ONE_Q30};
        return it;
    endfunction

    function automatic t_item f_acc(t_item it, logic sub);
        if (sub) begin
            it.sum = (it.sum > {1'b0, it.term}) ? (it.sum - {1'b0, it.term}) : 32'd0;
        end else begin
            it.sum = it.sum + {1'b0, it.term};
        end
        return it;
    endfunction

    function automatic t_item f_ser1(t_item it);
        logic [60:0] pr;
        pr = {30'b0, it.term} * {31'b0, it.xs};
        it.a = pr[60:30];
        return it;
    endfunction

    function automatic t_item f_ser2(t_item it, logic [32:0] recip);
        logic [63:0] pr;
        pr = {33'b0, it.a} * {31'b0, recip};
        it.q0h = pr[62:32];
        return it;
    endfunction

    // The reciprocal estimate is low by at most one; one compare fixes it.
    function automatic t_item f_ser3(t_item it, logic [4:0] n);
        logic [35:0] qn;
        logic [30:0] rem;
        qn  = {5'b0, it.q0h} * {31'b0, n};
        rem = it.a - qn[30:0];
        it.term = (rem >= {26'b0, n}) ? (it.q0h + 31'd1) : it.q0h;
        return it;
    endfunction

    function automatic t_item f_pow(t_item it);
        it.p = (it.ip >= 9'd31) ? 32'd0 : (it.sum >> it.ip[4:0]);
        return it;
    endfunction

    function automatic t_item f_usat(t_item it, logic [16:0] knee);
        it.usat = ({1'b0, it.v} >= {knee, 14'b0});
        it.ur   = {2'b0, it.v[29:14]};
        it.uq   = '0;
        return it;
    endfunction

    function automatic t_item f_udiv(t_item it, int b, logic [16:0] knee);
        logic [45:0] dv;
        logic [17:0] rr;
        dv = {it.v, 16'b0} >> b;
        rr = {it.ur[16:0], dv[0]};
        if (rr >= {1'b0, knee}) begin
            rr    = rr - {1'b0, knee};
            it.uq = it.uq | (30'd1 << b);
        end
        it.ur = rr;
        return it;
    endfunction

    function automatic t_item f_ss1(t_item it);
        logic [61:0] pr;
        it.u  = it.usat ? ONE_Q30 : {1'b0, it.uq};
        pr    = {31'b0, it.u} * {31'b0, it.u};
        it.u2 = pr[60:30];
        return it;
    endfunction

    function automatic t_item f_ss2(t_item it);
        logic [31:0] t3;
        logic [62:0] pr;
        t3 = THREE_Q30 - {it.u, 1'b0};
        pr = {32'b0, it.u2} * {31'b0, t3};
        it.sraw = pr[61:30];
        return it;
    endfunction

    function automatic t_item f_ss3(t_item it);
        it.s = (it.sraw > {1'b0, ONE_Q30}) ? ONE_Q30 : it.sraw[30:0];
        it.w = ONE_Q30 - it.s;
        return it;
    endfunction

    function automatic t_item f_mix1(t_item it);
        it.pa = {30'b0, it.s} * {31'b0, it.v};
        it.pb = {32'b0, it.w} * {31'b0, it.p};
        return it;
    endfunction

    function automatic t_item f_mix2(t_item it);
        logic [63:0] t;
        t = {3'b0, it.pa} + {1'b0, it.pb};
        it.r = (t[63:30] > {3'b0, ONE_Q30}) ? ONE_Q30 : t[60:30];
        return it;
    endfunction

    function automatic t_item f_mix3(t_item it, logic [15:0] pmax);
        it.rm = ({16'b0, it.r} * {31'b0, pmax}) + HALF_Q30;
        return it;
    endfunction

    function automatic t_item f_out(t_item it, logic [15:0] pmax);
        logic [16:0] c;
        c = it.rm[46:30];
        case (it.kind)
            KIND_ZERO:  it.code = 16'd0;
            KIND_FULL:  it.code = pmax;
            KIND_PLAIN: it.code = it.q;
            default:    it.code = (c > {1'b0, pmax}) ? pmax : c[15:0];
        endcase
        return it;
    endfunction

endpackage

// ===== rtl/core/tone_curve_pixel_mapper_top.sv =====
// Tone curve pixel mapper. Each grey pixel passes a levels stage (rescale between the
// black and white points, clamp to 0..1) and, below the knee, a blend of the linear value
// with value^gamma weighted by 1 - smoothstep(value/knee); the result is rounded to a code.
// One pixel can enter in every clock cycle while o_stall is low, and there is no dependence
// between pixels, so the sustained rate is one transaction per cycle unless the output side
// stalls. The pipeline depth is set by the 28 log2 squaring stages and the 16-term exp2
// series (three stages per term), which run beside the three restoring dividers.
// A two-entry output buffer (output register plus skid register) decouples the sides: the
// input keeps being accepted while a finished pixel waits, and o_stall rises only when the
// skid register is occupied. Configuration registers must be written only while the block
// holds no pixel in flight; a write with index 0..3 sets black, white, knee or gamma.
module tone_curve_pixel_mapper_top #(
    parameter int PIXEL_BITS = tcpm_pkg::PIXEL_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_pixel_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_pixel_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [16:0] i_cfg_data
);
    import tcpm_pkg::*;

    // Largest pixel code for the configured pixel width.
    localparam logic [15:0] PIX_MAX = 16'((32'd1 << PIXEL_BITS) - 32'd1);

    logic [16:0] r_black;
    logic [16:0] r_white;
    logic [16:0] r_knee;
    logic [14:0] r_gamma;

    t_item       r_pipe [0:DEPTH];
    t_item       n_pipe [0:DEPTH];
    logic [DEPTH:0] r_vld;

    logic        r_o_vld;
    logic [15:0] r_o_code;
    logic        r_s_vld;
    logic [15:0] r_s_code;

    logic        en;
    logic        arrive;
    logic        take;

    // The whole pipeline moves together; it holds only while the skid register is full.
    assign en     = !r_s_vld;
    assign o_stall = r_s_vld;
    assign arrive = en && r_vld[DEPTH];
    assign take   = r_o_vld && !i_stall;

    assign o_valid     = r_o_vld;
    assign o_pixel_out = r_o_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_black <= 17'd0;
            r_white <= 17'h10000;
            r_knee  <= 17'd0;
            r_gamma <= 15'd4096;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_BLACK: r_black <= i_cfg_data;
                CFG_WHITE: r_white <= i_cfg_data;
                CFG_KNEE:  r_knee  <= i_cfg_data;
                CFG_GAMMA: r_gamma <= i_cfg_data[14:0];
            endcase
        end
    end

    always_comb begin
        n_pipe[0]     = '0;
        n_pipe[0].pix = i_pixel_in;
    end

    // Each stage applies the steps scheduled for it; the parallel branches (code divider,
    // level divider, log2 units) touch separate fields of the same transaction record.
    for (genvar j = 1; j <= DEPTH; j++) begin : g_stage
        localparam bit IS_SER = (j >= ST_SER0) && (j < ST_SEREND);
        localparam int SN     = IS_SER ? ((j - ST_SER0) / SER_PHASES + 1) : 1;
        localparam int SPH    = IS_SER ? ((j - ST_SER0) % SER_PHASES) : 0;
        localparam logic [32:0] RECIP = 33'((64'd1 << 32) / SN);

        always_comb begin
            t_item it;
            it = r_pipe[j-1];
            if (j == ST_CLAMP) it = f_clamp(it, r_black, r_white, PIX_MAX);
            if (j == ST_LEVEL) it = f_level(it, PIX_MAX);
            if (j == ST_PROD)  it = f_prod(it, r_knee, PIX_MAX);
            if (j == ST_CLASS) it = f_class(it, r_knee);
            if ((j >= ST_DIV0) && (j < ST_DIV0 + PIXEL_BITS)) begin
                it = f_pdiv(it, ST_DIV0 + PIXEL_BITS - 1 - j);
            end
            if ((j >= ST_DIV0) && (j < ST_USAT)) begin
                it = f_vdiv(it, ST_USAT - 1 - j);
            end
            if ((j >= ST_DIV0) && (j < ST_SQR0)) begin
                it.ln = f_norm(it.ln, 32 >> (j - ST_DIV0));
                it.ld = f_norm(it.ld, 32 >> (j - ST_DIV0));
            end
            if ((j >= ST_SQR0) && (j < ST_DIFF)) begin
                it.ln = f_sqr(it.ln, j == ST_SQR0, ST_DIFF - 1 - j);
                it.ld = f_sqr(it.ld, j == ST_SQR0, ST_DIFF - 1 - j);
            end
            if (j == ST_DIFF) it = f_diff(it);
            if (j == ST_GEXP) it = f_gexp(it, r_gamma);
            if (j == ST_LNX)  it = f_lnx(it);
            if (IS_SER && (SPH == 0)) begin
                // Fold the previous term into the sum beside the next product.
                if (SN > 1) it = f_acc(it, ((SN - 1) % 2) == 1);
                it = f_ser1(it);
            end
            if (IS_SER && (SPH == 1)) it = f_ser2(it, RECIP);
            if (IS_SER && (SPH == 2)) it = f_ser3(it, 5'(SN));
            if (j == ST_SEREND) it = f_acc(it, 1'b0);
            if (j == ST_POW)    it = f_pow(it);
            if (j == ST_USAT)   it = f_usat(it, r_knee);
            if ((j >= ST_UDIV0) && (j < ST_SS1)) begin
                it = f_udiv(it, ST_SS1 - 1 - j, r_knee);
            end
            if (j == ST_SS1)  it = f_ss1(it);
            if (j == ST_SS2)  it = f_ss2(it);
            if (j == ST_SS3)  it = f_ss3(it);
            if (j == ST_MIX1) it = f_mix1(it);
            if (j == ST_MIX2) it = f_mix2(it);
            if (j == ST_MIX3) it = f_mix3(it, PIX_MAX);
            if (j == ST_OUT)  it = f_out(it, PIX_MAX);
            n_pipe[j] = it;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i <= DEPTH; i++) begin
                r_pipe[i] <= n_pipe[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[DEPTH-1:0], i_valid};
        end
    end

    // Output register with a skid register behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
            r_s_vld <= 1'b0;
        end else if (!r_o_vld || take) begin
            r_o_vld <= r_s_vld || arrive;
            r_s_vld <= 1'b0;
        end else if (arrive) begin
            r_s_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_o_vld || take) begin
            r_o_code <= r_s_vld ? r_s_code : r_pipe[DEPTH].code;
        end
        if (arrive) begin
            r_s_code <= r_pipe[DEPTH].code;
        end
    end

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
    import tcpm_pkg::*;

    // The end-of-run drain is sized from the mapper's pipeline latency; the watchdog
    // limit and the receiver hold-off are set separately.
    localparam int PIPE_LATENCY = 96;
    localparam int DRAIN_CYCLES = 2 * PIPE_LATENCY;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 4000;
    localparam logic [63:0] PIX_MAX = 64'd65535;
    localparam logic [63:0] UNIT    = 64'd65536;
    localparam logic [63:0] Q30_ONE = 64'd1 << 30;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [15:0] in_pixel;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] out_pixel;
    logic        cfg_we;
    t_cfg_idx    cfg_idx;
    logic [16:0] cfg_data;

    tone_curve_pixel_mapper_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .o_stall     (in_stall),
        .i_pixel_in  (in_pixel),
        .o_valid     (out_valid),
        .i_stall     (out_stall),
        .o_pixel_out (out_pixel),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    // Mirror of the configuration registers, updated whenever a register is written.
    logic [16:0] black_q;
    logic [16:0] white_q;
    logic [16:0] knee_q;
    logic [14:0] gamma_q;

    logic [15:0] pixels_to_send[$];
    logic [15:0] expected_codes[$];

    int send_idle_pct;
    int recv_stall_pct;
    int hold_requests;
    int hold_served;
    int hold_left;
    int mismatches;
    int pixels_sent;
    int pixels_checked;
    int blend_pixels;
    int quiet_cycles;

    initial begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // log2 of an integer in Q28: the exponent from the bit position, the fraction from
    // repeated squaring of the mantissa normalized to [1,2) in Q30.
    function automatic logic [63:0] log2_q28(logic [63:0] x);
        int          e;
        logic [63:0] t;
        logic [63:0] mant;
        logic [63:0] fr;
        if (x == 0) begin
            return 64'd0;
        end
        e = 0;
        t = x;
        fr = 64'd0;
        while (t > 1) begin
            t = t >> 1;
            e++;
        end
        mant = (e <= 30) ? (x << (30 - e)) : (x >> (e - 30));
        for (int i = 27; i >= 0; i--) begin
            mant = (mant * mant) >> 30;
            if (mant >= (Q30_ONE << 1)) begin
                mant = mant >> 1;
                fr = fr | (64'd1 << i);
            end
        end
        return (64'(e) << 28) | fr;
    endfunction

    // Full tone curve for one pixel under the current register values.
    function automatic logic [15:0] map_pixel(logic [15:0] pix);
        logic [63:0] k, num, den, hi, lo;
        logic [63:0] v, u, u2, s, w, p, r, code;
        logic [63:0] diff, ex, ip, fx, xs, term, sum, ln_n, ln_d;
        k = {48'b0, pix};
        if (black_q == 0 && white_q >= UNIT) begin
            num = k;
            den = PIX_MAX;
        end else begin
            hi = {47'b0, white_q};
            lo = {47'b0, black_q};
            if (hi < lo + 66) begin
                hi = lo + 66;
            end
            if (k * UNIT <= lo * PIX_MAX) begin
                return 16'd0;
            end
            num = k * UNIT - lo * PIX_MAX;
            den = (hi - lo) * PIX_MAX;
        end
        if (num == 0) begin
            return 16'd0;
        end
        if (num >= den) begin
            return 16'hFFFF;
        end
        if (knee_q == 0 || num * UNIT >= {47'b0, knee_q} * den) begin
            return 16'((2 * num * PIX_MAX + den) / (2 * den));
        end
        blend_pixels++;
        v = (num << 30) / den;
        u = (v << 16) / {47'b0, knee_q};
        if (u > Q30_ONE) begin
            u = Q30_ONE;
        end
        u2 = (u * u) >> 30;
        s = (u2 * (3 * Q30_ONE - 2 * u)) >> 30;
        if (s > Q30_ONE) begin
            s = Q30_ONE;
        end
        w = Q30_ONE - s;
        if (gamma_q == 0) begin
            p = Q30_ONE;
        end else begin
            ln_n = log2_q28(num);
            ln_d = log2_q28(den);
            diff = (ln_d > ln_n) ? ln_d - ln_n : 64'd0;
            ex = ({49'b0, gamma_q} * diff) >> 12;
            ip = ex >> 28;
            fx = ex & ((64'd1 << 28) - 1);
            if (ip >= 31) begin
                p = 64'd0;
            end else begin
                // exp(-x) by its series, alternating signs, clamped at zero on subtraction.
                xs = (fx * 64'd744261118) >> 28;
                term = Q30_ONE;
                sum = Q30_ONE;
                for (int n = 1; n <= 16; n++) begin
                    term = ((term * xs) >> 30) / n;
                    if (n % 2 == 1) begin
                        sum = (sum > term) ? sum - term : 64'd0;
                    end else begin
                        sum = sum + term;
                    end
                end
                p = sum >> ip;
            end
        end
        r = (s * v + w * p) >> 30;
        if (r > Q30_ONE) begin
            r = Q30_ONE;
        end
        code = (r * PIX_MAX + (Q30_ONE >> 1)) >> 30;
        if (code > PIX_MAX) begin
            code = PIX_MAX;
        end
        return code[15:0];
    endfunction

    // Driver: a transaction completes when valid is high and the block is not stalling.
    // A stalled pixel is held; otherwise the next one is offered or the sender idles.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_pixel <= 16'd0;
        end else begin
            if (in_valid && !in_stall) begin
                expected_codes.insert(expected_codes.size(), map_pixel(in_pixel));
                pixels_sent++;
            end
            if (!in_valid || !in_stall) begin
                if (pixels_to_send.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    in_pixel <= pixels_to_send.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall: random per phase, plus long hold-offs on request so that the
    // pipeline and its skid buffer fill and the input side is forced to stall.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            hold_left <= 0;
            hold_served <= 0;
        end else if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_served < hold_requests) begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_served <= hold_served + 1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Monitor: every output transaction is compared with the oldest predicted code.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            pixels_checked++;
            if (expected_codes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected output transaction: pixel_out=%0d", out_pixel);
                end
            end else begin
                if (out_pixel !== expected_codes[0]) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("pixel_out mismatch: expected %0d, got %0d",
                                 expected_codes[0], out_pixel);
                    end
                end
                void'(expected_codes.pop_front());
            end
        end
    end

    // Watchdog: counts cycles in which work is outstanding but nothing moves.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (in_valid || expected_codes.size() > 0) begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("[tone_curve_pixel_mapper_top] ERROR");
                $finish;
            end
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [16:0] value);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_BLACK: black_q = value;
            CFG_WHITE: white_q = value;
            CFG_KNEE:  knee_q  = value;
            default:   gamma_q = value[14:0];
        endcase
    endtask

    task automatic set_curve(logic [16:0] black, logic [16:0] white, logic [16:0] knee,
                             logic [14:0] gamma);
        write_reg(CFG_BLACK, black);
        write_reg(CFG_WHITE, white);
        write_reg(CFG_KNEE, knee);
        write_reg(CFG_GAMMA, {2'b0, gamma});
    endtask

    // Appends one pixel to the driver's pending list.
    task automatic add_pixel(logic [15:0] pix);
        pixels_to_send.insert(pixels_to_send.size(), pix);
    endtask

    // Random pixels weighted toward dark codes, where the blend lives, and both ends.
    task automatic queue_random(int count);
        int sel;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 7);
            if (sel < 4) begin
                add_pixel(16'($urandom));
            end else if (sel < 6) begin
                add_pixel(16'($urandom_range(0, 8191)));
            end else if (sel == 6) begin
                add_pixel(16'($urandom_range(0, 15)));
            end else begin
                add_pixel(16'($urandom_range(65520, 65535)));
            end
        end
    endtask

    task automatic queue_directed();
        logic [15:0] picks[$] = '{16'd0, 16'd1, 16'd2, 16'd255, 16'd4096, 16'd16384,
                                  16'd32767, 16'd32768, 16'h5555, 16'hAAAA, 16'd65534,
                                  16'd65535};
        foreach (picks[i]) begin
            add_pixel(picks[i]);
        end
    endtask

    task automatic run_phase(int send_pct, int recv_pct, int count, bit with_hold);
        @(negedge clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        queue_random(count);
        if (with_hold) begin
            hold_requests++;
        end
        do begin
            @(negedge clk);
        end while (pixels_to_send.size() > 0 || in_valid || expected_codes.size() > 0);
    endtask

    initial begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = CFG_BLACK;
        cfg_data       = 17'd0;
        black_q        = 17'd0;
        white_q        = 17'd65536;
        knee_q         = 17'd0;
        gamma_q        = 15'd4096;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests  = 0;
        mismatches     = 0;
        pixels_sent    = 0;
        pixels_checked = 0;
        blend_pixels   = 0;
        quiet_cycles   = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Reset values: the levels stage is bypassed and there is no blend.
        queue_directed();
        run_phase(0, 0, 150, 1'b0);

        // A typical display curve: gamma 2.2 below mid grey.
        set_curve(17'd4096, 17'd60000, 17'd32768, 15'd9011);
        queue_directed();
        run_phase(0, 0, 200, 1'b0);

        // Full-range knee with the largest exponent.
        set_curve(17'd0, 17'd65536, 17'd65536, 15'd32767);
        run_phase(48, 0, 220, 1'b0);

        // White equal to black, so the margin sets the white point; knee beyond 1.0
        // and a zero exponent.
        set_curve(17'd30000, 17'd30000, 17'd131071, 15'd0);
        queue_directed();
        run_phase(0, 48, 220, 1'b0);

        // Black above 1.0: every pixel maps to zero.
        set_curve(17'd70000, 17'd65536, 17'd0, 15'd4096);
        run_phase(29, 29, 150, 1'b0);

        // Widest white register and the smallest nonzero exponent, under a long hold-off.
        set_curve(17'd0, 17'd131071, 17'd20000, 15'd1);
        run_phase(0, 0, 250, 1'b1);

        // Random curves through the remaining idle patterns.
        for (int ph = 0; ph < 4; ph++) begin
            set_curve(17'($urandom_range(0, 20000)), 17'($urandom_range(20000, 65536)),
                      17'($urandom_range(0, 65536)), 15'($urandom_range(0, 32767)));
            run_phase((ph % 2) ? 48 : 29, (ph >= 2) ? 48 : 29, 200, ph == 1);
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Checked %0d of %0d pixels over ten curve settings, %0d through the blend.",
                 pixels_checked, pixels_sent, blend_pixels);
        $display("Mismatches: %0d, predictions left over: %0d.", mismatches,
                 expected_codes.size());
        if (mismatches == 0 && expected_codes.size() == 0) begin
            $display("[tone_curve_pixel_mapper_top] OK");
        end else begin
            $display("[tone_curve_pixel_mapper_top] ERROR");
        end
        $finish;
    end

endmodule
